[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define SBSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define SBSM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/sbsm_pkg.sv]
// Shared types and constants of the serial bank switch mapper.
`timescale 1ns / 1ps

package sbsm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHR_IS_RAM        = 2'd0;
    localparam logic [1:0] CFG_PRG_RAM_OVER_8K   = 2'd1;
    localparam logic [1:0] CFG_PRG_BANKING_FIXED = 2'd2;

    // Serial register targets, address bits 14:13.
    localparam logic [1:0] TGT_CONTROL = 2'd0;
    localparam logic [1:0] TGT_CHR0    = 2'd1;
    localparam logic [1:0] TGT_CHR1    = 2'd2;
    localparam logic [1:0] TGT_PRG     = 2'd3;

    localparam logic [1:0] PRG_MODE_DEFAULT = 2'd3;
    localparam logic [2:0] SHIFT_LAST       = 3'd4;
    localparam logic [2:0] RAM_AREA         = 3'b011;

    typedef struct packed {
        logic [4:0]  prg_bank_low;
        logic [4:0]  prg_bank_high;
        logic [4:0]  chr_bank_low;
        logic [4:0]  chr_bank_high;
        logic [1:0]  mirroring;
        logic        prg_ram_enabled;
        logic [1:0]  prg_ram_bank;
        logic        sram_write;
        logic [12:0] sram_offset;
        logic [7:0]  sram_data;
    } t_result;

endpackage

[sv/sbsm_core.sv]
// Mapper state, configuration registers and next-state logic for one CPU write.
`timescale 1ns / 1ps

module sbsm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic              i_cfg_data,
    input  logic              i_accept,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_write_data,
    input  logic [31:0]       i_cpu_cycle,
    output sbsm_pkg::t_result o_result
);
    import sbsm_pkg::*;

    // PRG windows for a mode, a 4-bit bank and the 256K half.
    function automatic logic [9:0] prg_map(input logic [1:0] mode, input logic [3:0] bank,
                                           input logic upper);
        logic [4:0] off;
        logic [4:0] sum;
        logic [4:0] even;
        off  = {upper, 4'b0000};
        sum  = {1'b0, bank} + off;
        even = {sum[4:1], 1'b0};
        case (mode)
            2'd0, 2'd1: prg_map = {even, even | 5'd1};
            2'd2:       prg_map = {off, sum};
            default:    prg_map = {sum, upper, 4'hF};
        endcase
    endfunction

    logic        r_chr_is_ram, r_prg_ram_over_8k, r_prg_banking_fixed;
    logic [4:0]  r_shift, n_shift;
    logic [2:0]  r_count, n_count;
    logic [31:0] r_last, n_last;
    logic [1:0]  r_prg_mode, n_prg_mode;
    logic        r_chr_mode, n_chr_mode;
    logic        r_ram_en, n_ram_en;
    logic [3:0]  r_prg_reg, n_prg_reg;
    logic [4:0]  r_chr_reg0, n_chr_reg0;
    logic [4:0]  r_chr_reg1, n_chr_reg1;
    logic        r_upper, n_upper;
    logic [4:0]  r_prg_win0, n_prg_win0, r_prg_win1, n_prg_win1;
    logic [4:0]  r_chr_win0, n_chr_win0, r_chr_win1, n_chr_win1;
    logic [1:0]  r_ram_bank, n_ram_bank;
    logic [1:0]  r_mirror, n_mirror;

    always_comb begin
        logic       ram_area;
        logic       reg_write;
        logic       do_all, do_chr, do_prg, slot;
        logic [4:0] shifted, bank, cb0, cb1;
        logic       upper_f;
        logic [9:0] pw;

        n_shift    = r_shift;
        n_count    = r_count;
        n_last     = r_last;
        n_prg_mode = r_prg_mode;
        n_chr_mode = r_chr_mode;
        n_ram_en   = r_ram_en;
        n_prg_reg  = r_prg_reg;
        n_chr_reg0 = r_chr_reg0;
        n_chr_reg1 = r_chr_reg1;
        n_upper    = r_upper;
        n_prg_win0 = r_prg_win0;
        n_prg_win1 = r_prg_win1;
        n_chr_win0 = r_chr_win0;
        n_chr_win1 = r_chr_win1;
        n_ram_bank = r_ram_bank;
        n_mirror   = r_mirror;

        o_result.sram_write  = 1'b0;
        o_result.sram_offset = '0;
        o_result.sram_data   = '0;

        ram_area  = (i_address[15:13] == RAM_AREA);
        reg_write = i_address[15] && ((r_last + 32'd1) != i_cpu_cycle);
        do_all    = 1'b0;
        do_chr    = 1'b0;
        do_prg    = 1'b0;
        slot      = 1'b0;
        bank      = '0;
        cb0       = '0;
        cb1       = '0;
        upper_f   = r_upper;
        pw        = '0;
        shifted   = r_shift | ({4'b0000, i_write_data[0]} << r_count);

        if (i_accept) begin
            if (ram_area) begin
                if (r_ram_en) begin
                    o_result.sram_write  = 1'b1;
                    o_result.sram_offset = i_address[12:0];
                    o_result.sram_data   = i_write_data;
                end
            end else if (reg_write) begin
                n_last = i_cpu_cycle;
                if (i_write_data[7]) begin
                    n_shift    = '0;
                    n_count    = '0;
                    n_prg_mode = PRG_MODE_DEFAULT;
                    n_chr_mode = 1'b0;
                    n_ram_en   = 1'b1;
                    n_ram_bank = '0;
                    do_all     = 1'b1;
                end else if (r_count == SHIFT_LAST) begin
                    n_shift = '0;
                    n_count = '0;
                    case (i_address[14:13])
                        TGT_CONTROL: begin
                            n_prg_mode = shifted[3:2];
                            n_chr_mode = shifted[4];
                            n_mirror   = shifted[1:0];
                            do_all     = 1'b1;
                        end
                        TGT_CHR0: begin
                            n_chr_reg0 = shifted;
                            do_chr     = 1'b1;
                            bank       = shifted;
                        end
                        TGT_CHR1: begin
                            n_chr_reg1 = shifted;
                            do_chr     = 1'b1;
                            slot       = 1'b1;
                            bank       = shifted;
                        end
                        default: begin
                            n_ram_en  = !shifted[4];
                            n_prg_reg = shifted[3:0];
                            do_prg    = 1'b1;
                        end
                    endcase
                end else begin
                    n_shift = shifted;
                    n_count = r_count + 3'd1;
                end
            end
        end

        // Re-apply the windows (PRG unless fixed); CHR1 sets 256K half and RAM bank.
        if (do_all) begin
            upper_f = r_chr_is_ram ? n_chr_reg1[4] : r_upper;
            n_upper = upper_f;
            if (r_chr_is_ram && r_prg_ram_over_8k) begin
                n_ram_bank = n_chr_reg1[3:2];
            end
            if (!r_prg_banking_fixed) begin
                pw         = prg_map(n_prg_mode, n_prg_reg, upper_f);
                n_prg_win0 = pw[9:5];
                n_prg_win1 = pw[4:0];
            end
            cb0 = r_chr_is_ram ? {4'b0000, n_chr_reg0[0]} : n_chr_reg0;
            cb1 = r_chr_is_ram ? {4'b0000, n_chr_reg1[0]} : n_chr_reg1;
            if (n_chr_mode) begin
                n_chr_win0 = cb0;
                n_chr_win1 = cb1;
            end else begin
                n_chr_win0 = {cb0[4:1], 1'b0};
                n_chr_win1 = {cb0[4:1], 1'b1};
            end
        end

        // Single CHR register write; the PRG windows move only if the 256K half flips.
        if (do_chr) begin
            cb0 = bank;
            if (r_chr_is_ram) begin
                if (bank[4] != r_upper) begin
                    n_upper = bank[4];
                    if (!r_prg_banking_fixed) begin
                        pw         = prg_map(r_prg_mode, r_prg_reg, bank[4]);
                        n_prg_win0 = pw[9:5];
                        n_prg_win1 = pw[4:0];
                    end
                end
                if (r_prg_ram_over_8k) begin
                    n_ram_bank = bank[3:2];
                end
                cb0 = {4'b0000, bank[0]};
            end
            if (r_chr_mode) begin
                if (slot) begin
                    n_chr_win1 = cb0;
                end else begin
                    n_chr_win0 = cb0;
                end
            end else if (!slot) begin
                n_chr_win0 = {cb0[4:1], 1'b0};
                n_chr_win1 = {cb0[4:1], 1'b1};
            end
        end

        if (do_prg && !r_prg_banking_fixed) begin
            pw         = prg_map(r_prg_mode, n_prg_reg, r_upper);
            n_prg_win0 = pw[9:5];
            n_prg_win1 = pw[4:0];
        end

        o_result.prg_bank_low    = n_prg_win0;
        o_result.prg_bank_high   = n_prg_win1;
        o_result.chr_bank_low    = n_chr_win0;
        o_result.chr_bank_high   = n_chr_win1;
        o_result.mirroring       = n_mirror;
        o_result.prg_ram_enabled = n_ram_en;
        o_result.prg_ram_bank    = n_ram_bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_is_ram        <= 1'b0;
            r_prg_ram_over_8k   <= 1'b0;
            r_prg_banking_fixed <= 1'b0;
            r_shift    <= '0;
            r_count    <= '0;
            r_last     <= '0;
            r_prg_mode <= PRG_MODE_DEFAULT;
            r_chr_mode <= 1'b0;
            r_ram_en   <= 1'b1;
            r_prg_reg  <= '0;
            r_chr_reg0 <= '0;
            r_chr_reg1 <= '0;
            r_upper    <= 1'b0;
            r_prg_win0 <= 5'd0;
            r_prg_win1 <= 5'd15;
            r_chr_win0 <= 5'd0;
            r_chr_win1 <= 5'd1;
            r_ram_bank <= '0;
            r_mirror   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CHR_IS_RAM:        r_chr_is_ram        <= i_cfg_data;
                    CFG_PRG_RAM_OVER_8K:   r_prg_ram_over_8k   <= i_cfg_data;
                    CFG_PRG_BANKING_FIXED: r_prg_banking_fixed <= i_cfg_data;
                    default: ;
                endcase
            end
            r_shift    <= n_shift;
            r_count    <= n_count;
            r_last     <= n_last;
            r_prg_mode <= n_prg_mode;
            r_chr_mode <= n_chr_mode;
            r_ram_en   <= n_ram_en;
            r_prg_reg  <= n_prg_reg;
            r_chr_reg0 <= n_chr_reg0;
            r_chr_reg1 <= n_chr_reg1;
            r_upper    <= n_upper;
            r_prg_win0 <= n_prg_win0;
            r_prg_win1 <= n_prg_win1;
            r_chr_win0 <= n_chr_win0;
            r_chr_win1 <= n_chr_win1;
            r_ram_bank <= n_ram_bank;
            r_mirror   <= n_mirror;
        end
    end

endmodule

[sv/serial_bank_switch_mapper_unit.sv]
// Serial bank switch mapper: CPU write in, bank windows and PRG RAM strobe out, one
// result per accepted transaction. A write is decoded, shifted in and applied to the
// window registers in the cycle it is accepted, and its result is registered, so the
// block takes one transaction per clock while o_stall is low. A two-entry output
// stage (result register plus skid register) lets input keep flowing while a result
// waits; o_stall rises only when both entries hold results. Configuration is written
// through a plain write port and takes effect on the next transaction.
`timescale 1ns / 1ps

module serial_bank_switch_mapper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [31:0] i_cpu_cycle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_prg_bank_low,
    output logic [4:0]  o_prg_bank_high,
    output logic [4:0]  o_chr_bank_low,
    output logic [4:0]  o_chr_bank_high,
    output logic [1:0]  o_mirroring,
    output logic        o_prg_ram_enabled,
    output logic [1:0]  o_prg_ram_bank,
    output logic        o_sram_write,
    output logic [12:0] o_sram_offset,
    output logic [7:0]  o_sram_data
);
    import sbsm_pkg::*;

    t_result w_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept, w_take;

    assign w_accept = i_valid && !r_skid_valid;
    assign w_take   = r_out_valid && !i_stall;

    sbsm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_cpu_cycle  (i_cpu_cycle),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            // Output register free: drain the skid first, else load the new transaction.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_stall           = r_skid_valid;
    assign o_valid           = r_out_valid;
    assign o_prg_bank_low    = r_out.prg_bank_low;
    assign o_prg_bank_high   = r_out.prg_bank_high;
    assign o_chr_bank_low    = r_out.chr_bank_low;
    assign o_chr_bank_high   = r_out.chr_bank_high;
    assign o_mirroring       = r_out.mirroring;
    assign o_prg_ram_enabled = r_out.prg_ram_enabled;
    assign o_prg_ram_bank    = r_out.prg_ram_bank;
    assign o_sram_write      = r_out.sram_write;
    assign o_sram_offset     = r_out.sram_offset;
    assign o_sram_data       = r_out.sram_data;

endmodule

[sv/sbsm_checker.sv]
// Port-level checks of the serial bank switch mapper, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [4:0]  o_prg_bank_low,
    input logic [4:0]  o_prg_bank_high,
    input logic        o_sram_write,
    input logic [12:0] o_sram_offset,
    input logic [7:0]  o_sram_data
);

    `SBSM_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "result dropped while stalled")
    `SBSM_ASSERT(a_out_stable, o_valid && i_stall |=> $stable(o_prg_bank_low) && $stable(o_prg_bank_high), "stalled result changed")
    `SBSM_ASSERT(a_skid_order, o_stall |-> o_valid, "skid entry held with empty output register")
    `SBSM_ASSERT(a_sram_quiet, o_valid && !o_sram_write |-> o_sram_offset == 13'd0 && o_sram_data == 8'd0, "RAM fields set without a RAM write")
    `SBSM_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid && !o_stall, "output not empty after reset")

endmodule

bind serial_bank_switch_mapper_unit sbsm_checker u_sbsm_checker (.*);
